### sv/assert_macros.svh
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)

`define ASSERT_CLK_NORST(label, clk, prop, msg)

`endif

`endif

### sv/lpas_pkg.sv
package lpas_pkg;

  localparam int ADDR_W          = 48;
  localparam int HOME_SHIFT      = 4;
  localparam int HOME_W          = ADDR_W - HOME_SHIFT;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int PROBE_LIMIT_DEF = 100;

  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // status of the home slot reduction unit
  typedef struct packed {
    logic busy;
    logic done;
  } home_stat_t;

endpackage

### sv/lpas_table_ram.sv
module lpas_table_ram #(
  parameter int TABLE_DEPTH = lpas_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [lpas_pkg::ADDR_W-1:0] wdata,
  input  logic [IDX_W-1:0]            raddr,
  output logic [lpas_pkg::ADDR_W-1:0] rdata
);
  import lpas_pkg::*;

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/lpas_home_slot.sv
// Home slot: (address >> 4) mod TABLE_DEPTH. TABLE_DEPTH is a power of two,
// so the reduction keeps the low index bits; the slot is registered and done
// pulses in the next cycle.
module lpas_home_slot #(
  parameter int TABLE_DEPTH = lpas_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lpas_pkg::HOME_W-1:0] value,
  output lpas_pkg::home_stat_t        stat,
  output logic [IDX_W-1:0]            slot
);
  import lpas_pkg::*;

  logic [IDX_W-1:0] home;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      home <= value[IDX_W-1:0];
    end
  end

  // busy only while a value is being taken in
  assign stat.busy = start;
  assign stat.done = done;
  assign slot      = home;

endmodule

### sv/linear_probe_address_set.sv
// Channel  Dir  tdata                          tuser
// s_axis   in   [47:0] address                 [0] operation (0 mark, 1 check)
// m_axis   out  [0] found, [1] stored, [7:2] 0 -
//
// One item at a time. Steps per transaction: the home slot (low index bits of address >> 4,
// TABLE_DEPTH a power of two), the issue of the first read, n probes on the single table
// read port (n is 1..PROBE_LIMIT), and the load of the result. A zero address goes
// straight from idle to the result load.
// After rst the table is cleared one entry per cycle, with s_axis_tready low. A held
// result on m_axis stalls only the end of the next item.
module linear_probe_address_set #(
  parameter int TABLE_DEPTH = lpas_pkg::TABLE_DEPTH_DEF,
  parameter int PROBE_LIMIT = lpas_pkg::PROBE_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lpas_pkg::ADDR_W-1:0] s_axis_tdata,  // [47:0] address
  input  logic                        s_axis_tuser,  // [0] operation
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata   // [0] found, [1] stored
);
  import lpas_pkg::*;

  `include "assert_macros.svh"

  localparam int               IDX_W  = $clog2(TABLE_DEPTH);
  localparam int               PCNT_W = $clog2(PROBE_LIMIT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [PCNT_W-1:0] LAST_PRB  = PCNT_W'(PROBE_LIMIT - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_HOME   = 6'b000100,
    ST_ISSUE  = 6'b001000,
    ST_PROBE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              op;
  logic [ADDR_W-1:0] addr;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  slot_inc;
  logic [IDX_W-1:0]  clr_idx;
  logic [PCNT_W-1:0] probe_cnt;
  logic              found;
  logic              stored;

  logic              accept;
  logic              home_start;
  home_stat_t        home_stat;
  logic [IDX_W-1:0]  home_slot;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  logic              hit;
  logic              empty;
  logic              stop;
  logic              out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign home_start    = accept && (s_axis_tdata != '0);
  assign slot_inc      = (slot == LAST_IDX) ? '0 : slot + 1'b1;
  assign hit           = (ram_rdata == addr);
  assign empty         = (ram_rdata == '0);
  assign out_load      = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  // the probe ends on a hit, on an empty entry or at the probe limit
  assign stop = hit || empty || (probe_cnt == LAST_PRB);

  lpas_home_slot #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (home_start),
    .value (s_axis_tdata[ADDR_W-1:HOME_SHIFT]),
    .stat  (home_stat),
    .slot  (home_slot)
  );

  lpas_table_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = slot;
    ram_wdata  = addr;
    ram_raddr  = slot;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_axis_tdata == '0) ? ST_FINISH : ST_HOME;
        end
      end
      ST_HOME: begin
        if (home_stat.done) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        if (op == OP_MARK) begin
          if (hit || empty) begin
            ram_we = 1'b1;
          end
        end else if (hit) begin
          ram_we    = 1'b1;
          ram_wdata = '0;
        end
        if (stop) begin
          state_next = ST_FINISH;
        end else begin
          ram_raddr = slot_inc;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= s_axis_tuser;
      addr   <= s_axis_tdata;
      found  <= 1'b0;
      stored <= 1'b0;
    end
    if (state == ST_HOME && home_stat.done) begin
      slot      <= home_slot;
      probe_cnt <= '0;
    end
    if (state == ST_PROBE) begin
      if (!stop) begin
        slot      <= slot_inc;
        probe_cnt <= probe_cnt + 1'b1;
      end
      if (op == OP_MARK) begin
        stored <= hit || empty;
      end else begin
        found <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'b0, stored, found};
    end
  end

  `ASSERT_CLK(a_one_flag, clk, rst, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "found and stored both set")
  `ASSERT_CLK_NORST(a_no_accept_clear, clk, (state == ST_CLEAR) |-> !s_axis_tready, "item accepted during table clear")
  `ASSERT_CLK(a_write_ends_probe, clk, rst, (state == ST_PROBE && ram_we) |=> (state == ST_FINISH), "table written without ending the probe")
  `ASSERT_CLK(a_probe_bound, clk, rst, (state == ST_PROBE) |-> (probe_cnt <= LAST_PRB), "probe count beyond limit")
  `ASSERT_CLK(a_home_busy, clk, rst, (state == ST_HOME && !home_stat.done) |-> home_stat.busy, "waiting on idle home unit")

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpas_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int PROBE_LIMIT = PROBE_LIMIT_DEF;
  localparam int HOME_BITS   = $clog2(TABLE_DEPTH);
  localparam int RAND_ITEMS  = 1200;
  localparam int HOLD_CYCLES = 1000;
  localparam int N_ROWS      = 18;

  typedef struct packed {
    logic found;
    logic stored;
  } flags_t;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    bit                typed;   // expected flags given in the row
    logic              found;
    logic              stored;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [ADDR_W-1:0] s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;

  bit [ADDR_W-1:0] shadow_table [TABLE_DEPTH];
  flags_t          expected_flags [$];
  bit [ADDR_W-1:0] marked_addrs [$];
  int              fail_count;
  int              results_seen;
  logic            rx_hold;

  // Directed items: empty table, zero address, extremes, wrap at the last entry,
  // re-mark of a member, and a removal hole that hides a later member.
  stim_row_t directed_rows [N_ROWS] = '{
    '{OP_CHECK, 48'h1234_5678_9ab0, 1'b1, 1'b0, 1'b0},
    '{OP_MARK,  48'h0000_0000_0000, 1'b1, 1'b0, 1'b0},
    '{OP_CHECK, 48'h0000_0000_0000, 1'b1, 1'b0, 1'b0},
    '{OP_MARK,  48'hffff_ffff_ffff, 1'b1, 1'b0, 1'b1},
    '{OP_MARK,  48'h0000_0000_0001, 1'b1, 1'b0, 1'b1},
    '{OP_MARK,  48'hffff_ffff_ffff, 1'b1, 1'b0, 1'b1},
    '{OP_CHECK, 48'hffff_ffff_ffff, 1'b1, 1'b1, 1'b0},
    '{OP_CHECK, 48'hffff_ffff_ffff, 1'b1, 1'b0, 1'b0},
    '{OP_MARK,  48'h0000_0000_fff0, 1'b1, 1'b0, 1'b1},
    '{OP_MARK,  48'h8000_0000_fff3, 1'b0, 1'b0, 1'b0},
    '{OP_CHECK, 48'h8000_0000_fff3, 1'b0, 1'b0, 1'b0},
    '{OP_MARK,  48'h5555_5555_0020, 1'b0, 1'b0, 1'b0},
    '{OP_MARK,  48'haaaa_aaaa_0020, 1'b0, 1'b0, 1'b0},
    '{OP_CHECK, 48'h5555_5555_0020, 1'b0, 1'b0, 1'b0},
    '{OP_CHECK, 48'haaaa_aaaa_0020, 1'b0, 1'b0, 1'b0},
    '{OP_MARK,  48'h0000_0000_000f, 1'b0, 1'b0, 1'b0},
    '{OP_CHECK, 48'h0000_0000_0001, 1'b0, 1'b0, 1'b0},
    '{OP_CHECK, 48'h0000_0000_fff0, 1'b0, 1'b0, 1'b0}
  };

  linear_probe_address_set DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int home_slot(bit [ADDR_W-1:0] a);
    return int'((a >> HOME_SHIFT) % TABLE_DEPTH);
  endfunction

  function automatic bit table_mark(bit [ADDR_W-1:0] a);
    int home;
    int slot;
    int i;
    home = home_slot(a);
    for (i = 0; i < PROBE_LIMIT; i++) begin
      slot = (home + i) % TABLE_DEPTH;
      if (shadow_table[slot] == '0 || shadow_table[slot] == a) begin
        shadow_table[slot] = a;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // stops at the first empty entry; a removed entry leaves no tombstone
  function automatic bit table_check(bit [ADDR_W-1:0] a);
    int home;
    int slot;
    int i;
    home = home_slot(a);
    for (i = 0; i < PROBE_LIMIT; i++) begin
      slot = (home + i) % TABLE_DEPTH;
      if (shadow_table[slot] == a) begin
        shadow_table[slot] = '0;
        return 1'b1;
      end
      if (shadow_table[slot] == '0) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic flags_t predict_flags(logic op, bit [ADDR_W-1:0] a);
    flags_t f;
    f = '0;
    if (a != '0) begin
      if (op == OP_MARK) begin
        f.stored = table_mark(a);
      end else begin
        f.found = table_check(a);
      end
    end
    return f;
  endfunction

  // addresses crowding a few home slots, one window straddling the wrap
  function automatic bit [ADDR_W-1:0] cluster_addr();
    bit [ADDR_W-1:0] a;
    int              home;
    home = ($urandom_range(0, 1) ? TABLE_DEPTH - 4 : TABLE_DEPTH / 3)
           + $urandom_range(0, 7);
    a = {16'($urandom()), 32'($urandom())};
    a[HOME_SHIFT +: HOME_BITS] = HOME_BITS'(home % TABLE_DEPTH);
    return a;
  endfunction

  task automatic offer_item(input logic op, input logic [ADDR_W-1:0] addr,
                            input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || rx_hold) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // stimulus
  initial begin
    int              k;
    int unsigned     r;
    logic            op;
    bit [ADDR_W-1:0] addr;
    flags_t          f;
    bit              steady_tx;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_MARK;
    fail_count    = 0;
    steady_tx     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_ROWS; k++) begin
      offer_item(directed_rows[k].op, directed_rows[k].addr, pick_gap(1'b0));
      f = predict_flags(directed_rows[k].op, directed_rows[k].addr);
      if (directed_rows[k].typed) begin
        f.found  = directed_rows[k].found;
        f.stored = directed_rows[k].stored;
      end
      expected_flags.push_back(f);
    end
    drain_results();

    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 100 == 0) steady_tx = ($urandom_range(0, 3) == 0);
      if (k == RAND_ITEMS / 2) drain_results();
      r = $urandom_range(0, 99);
      op = $urandom_range(0, 99) < 60 ? OP_MARK : OP_CHECK;
      if (r < 3) begin
        addr = '0;
      end else if (r < 10) begin
        addr = {16'($urandom()), 32'($urandom())};
      end else if (op == OP_CHECK && marked_addrs.size() != 0 &&
                   $urandom_range(0, 9) < 7) begin
        addr = marked_addrs[$urandom_range(0, marked_addrs.size() - 1)];
      end else begin
        addr = cluster_addr();
      end
      offer_item(op, addr, pick_gap(steady_tx));
      expected_flags.push_back(predict_flags(op, addr));
      if (op == OP_MARK && addr != '0) begin
        marked_addrs.push_back(addr);
        if (marked_addrs.size() > 64) void'(marked_addrs.pop_front());
      end
    end
    drain_results();
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int     stall;
    int     cyc;
    bit     held;
    bit     steady_rx;
    flags_t e;

    m_axis_tready <= 1'b0;
    rx_hold       <= 1'b0;
    results_seen  = 0;
    stall         = 0;
    cyc           = 0;
    held          = 1'b0;
    steady_rx     = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_flags.size() == 0) begin
          $error("unexpected result transaction, tdata=%h", m_axis_tdata);
          fail_count++;
        end else begin
          e = expected_flags.pop_front();
          if (m_axis_tdata[0] !== e.found) begin
            $error("found: expected %0b, got %0b", e.found, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tdata[1] !== e.stored) begin
            $error("stored: expected %0b, got %0b", e.stored, m_axis_tdata[1]);
            fail_count++;
          end
          if (m_axis_tdata[7:2] !== 6'd0) begin
            $error("pad: expected 0, got %0h", m_axis_tdata[7:2]);
            fail_count++;
          end
        end
      end
      if (cyc % 256 == 0) steady_rx = ($urandom_range(0, 3) == 0);

      if (!held && results_seen == 300) begin
        held = 1'b1;
        rx_hold       <= 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold       <= 1'b0;
        m_axis_tready <= 1'b1;
      end else if (steady_rx) begin
        stall = 0;
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 6) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                             : $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
